// File: sv/utf16_to_utf8_transcoder_macros.svh
// Assertion macros shared by the transcoder modules.
// No dependencies; included by the files that carry assertions.
`ifndef UTF16_TO_UTF8_TRANSCODER_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: sv/utt_pkg.sv
// Shared types, constants and the byte encoder for the UTF-16 to UTF-8 transcoder.
// No dependencies.
package utt_pkg;

	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);

	localparam logic [20:0] SuppBase = 21'h10000;

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_INVALID = 2'd1,
		KIND_PARTIAL = 2'd2
	} kind_t;

	// One classified unit: a code point to encode, or an error report.
	typedef struct packed {
		logic [20:0] cp;
		logic [1:0]  last_idx;  // number of bytes minus one
		kind_t       kind;
		logic        str_end;
	} job_t;

	// Byte idx of the UTF-8 form of cp, which is last_idx+1 bytes long.
	function automatic logic [7:0] utt_byte(logic [20:0] cp, logic [1:0] last_idx,
			logic [1:0] idx);
		logic [1:0] rem;
		logic [7:0] b;
		rem = last_idx - idx;
		if (idx == 2'd0) begin
			unique case (last_idx)
				2'd0: b = {1'b0, cp[6:0]};
				2'd1: b = {3'b110, cp[10:6]};
				2'd2: b = {4'b1110, cp[15:12]};
				2'd3: b = {5'b11110, cp[20:18]};
			endcase
		end else begin
			unique case (rem)
				2'd0: b = {2'b10, cp[5:0]};
				2'd1: b = {2'b10, cp[11:6]};
				2'd2: b = {2'b10, cp[17:12]};
				2'd3: b = 8'h80;  // lead byte handled above
			endcase
		end
		return b;
	endfunction

endpackage

// File: sv/utt_queue.sv
// Short job queue between the classifier and the byte serializer.
// Depends on utt_pkg and the assertion macro header.
`include "utf16_to_utf8_transcoder_macros.svh"

module utt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  utt_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output utt_pkg::job_t head
);
	import utt_pkg::*;

	job_t           mem_q [QDepth];
	logic [QAw-1:0] wr_ptr_q;
	logic [QAw-1:0] rd_ptr_q;
	logic [QAw:0]   cnt_q;

	assign full       = (cnt_q == (QAw+1)'(QDepth));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`UTT_ASSERT_IMPL(a_no_overflow, clk, arst_n, push, !full)
	`UTT_ASSERT_IMPL(a_no_underflow, clk, arst_n, pop, head_valid)

endmodule

// File: sv/utt_front.sv
// Front end: accepts code units, tracks surrogate/skip state, emits jobs.
// Depends on utt_pkg and the assertion macro header.
`include "utf16_to_utf8_transcoder_macros.svh"

module utt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [15:0]   code_unit,
	input  logic          last_unit,
	input  logic          cfg_wr_en,
	input  logic          cfg_wr_data,
	input  logic          q_full,
	output logic          push,
	output utt_pkg::job_t job
);
	import utt_pkg::*;

	logic       allow_q;
	logic       pend_q;
	logic [9:0] pend_hi_q;
	logic       skip_q;

	logic       accept;
	logic       ends;
	logic       is_low;
	logic       is_high;
	logic       want_push;
	logic       pend_d;
	logic [9:0] pend_hi_d;
	logic       skip_d;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && want_push;

	assign ends    = last_unit || (code_unit == 16'h0000);
	assign is_low  = (code_unit[15:10] == 6'b110111);
	assign is_high = (code_unit[15:10] == 6'b110110);

	always_comb begin
		want_push    = 1'b0;
		job.cp       = {5'd0, code_unit};
		job.last_idx = 2'd0;
		job.kind     = KIND_DATA;
		job.str_end  = last_unit;
		pend_d       = pend_q;
		pend_hi_d    = pend_hi_q;
		skip_d       = skip_q;
		priority if (skip_q) begin
			if (ends) begin
				skip_d = 1'b0;
				pend_d = 1'b0;
			end
		end else if (code_unit == 16'h0000) begin
			want_push   = pend_q && !allow_q;
			job.kind    = KIND_PARTIAL;
			job.cp      = '0;
			job.str_end = 1'b1;
			pend_d      = 1'b0;
		end else if (is_low && pend_q) begin
			want_push    = 1'b1;
			job.cp       = {1'b0, pend_hi_q, code_unit[9:0]} + SuppBase;
			job.last_idx = 2'd3;
			pend_d       = 1'b0;
		end else if (is_low || pend_q) begin
			// lone low surrogate, or held high not followed by a low one
			want_push = 1'b1;
			job.kind  = KIND_INVALID;
			job.cp    = '0;
			pend_d    = 1'b0;
			skip_d    = !last_unit;
		end else if (is_high) begin
			if (last_unit) begin
				want_push   = !allow_q;
				job.kind    = KIND_PARTIAL;
				job.cp      = '0;
			end else begin
				pend_d    = 1'b1;
				pend_hi_d = code_unit[9:0];
			end
		end else begin
			want_push = 1'b1;
			priority if (code_unit[15:7] == '0) begin
				job.last_idx = 2'd0;
			end else if (code_unit[15:11] == '0) begin
				job.last_idx = 2'd1;
			end else begin
				job.last_idx = 2'd2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_q   <= 1'b0;
			pend_q    <= 1'b0;
			pend_hi_q <= '0;
			skip_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				allow_q <= cfg_wr_data;
			end
			if (accept) begin
				pend_q    <= pend_d;
				pend_hi_q <= pend_hi_d;
				skip_q    <= skip_d;
			end
		end
	end

	`UTT_ASSERT_IMPL(a_pend_skip_excl, clk, arst_n, 1'b1, !(pend_q && skip_q))

endmodule

// File: sv/utt_back.sv
// Back end: walks each queued job out as one result beat per cycle unless out_stall holds it.
// Depends on utt_pkg and the assertion macro header.
`include "utf16_to_utf8_transcoder_macros.svh"

module utt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  utt_pkg::job_t head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    utf8_byte,
	output logic [1:0]    kind,
	output logic          run_end,
	output logic          string_end
);
	import utt_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic [1:0] kind_q;
	logic       run_end_q;
	logic       string_end_q;

	logic       load;
	logic       at_last;

	assign load    = head_valid && (!out_valid_q || !out_stall);
	assign at_last = (idx_q == head.last_idx);
	assign pop     = load && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_last ? 2'd0 : idx_q + 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q       <= (head.kind == KIND_DATA) ? utt_byte(head.cp, head.last_idx, idx_q)
			                                         : 8'h00;
			kind_q       <= head.kind;
			run_end_q    <= at_last;
			string_end_q <= at_last && head.str_end;
		end
	end

	assign out_valid  = out_valid_q;
	assign utf8_byte  = byte_q;
	assign kind       = kind_q;
	assign run_end    = run_end_q;
	assign string_end = string_end_q;

	`UTT_ASSERT_IMPL(a_err_single, clk, arst_n, out_valid && (kind != KIND_DATA),
		run_end && (utf8_byte == 8'h00))
	`UTT_ASSERT_IMPL(a_send_on_run_end, clk, arst_n, out_valid && string_end, run_end)
	`UTT_ASSERT_IMPL(a_idx_bound, clk, arst_n, head_valid, idx_q <= head.last_idx)

endmodule

// File: sv/utf16_to_utf8_transcoder.sv
// Top level of the UTF-16 to UTF-8 transcoder.
// Depends on utt_pkg, utt_front, utt_queue and utt_back.
//
// Takes one UTF-16 code unit per input beat and produces one result beat per
// UTF-8 byte. A string ends on a unit with last_unit set or on a zero unit
// (which is never encoded). A high surrogate is held and produces nothing; the
// low surrogate after it yields four bytes. Errors come out as a single beat
// with kind 1 (invalid sequence) or kind 2 (partial sequence at end) and byte
// zero; after an invalid sequence the rest of the string is dropped silently.
// Bytes already sent before an error are not recalled: the consumer discards
// them. run_end marks the last beat caused by a unit, string_end the beat that
// closes a string. Setting allow_trailing_partial (cfg_wr_data on a cycle with
// cfg_wr_en) drops a dangling high surrogate at end of string without a
// report; write it only while the block is idle.
// Throughput: the single output register sends one byte per cycle while
// out_stall is low, so a unit's output cost grows with the beats it produces
// (1 to 4; zero-beat units cost nothing on the output side). The input side
// takes a unit every cycle while the four-entry job queue has room, so input
// and output stall independently. An input beat is written into the job
// queue, and its first output beat is then loaded into the output register.

module utf16_to_utf8_transcoder (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] code_unit,
	input  logic        last_unit,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  utf8_byte,
	output logic [1:0]  kind,
	output logic        run_end,
	output logic        string_end
);
	import utt_pkg::*;

	logic q_full;
	logic q_push;
	job_t q_in_job;
	logic q_pop;
	logic q_head_valid;
	job_t q_head;

	// classify units and track surrogate / skip state
	utt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.code_unit   (code_unit),
		.last_unit   (last_unit),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_full      (q_full),
		.push        (q_push),
		.job         (q_in_job)
	);

	// decouples unit intake from byte output
	utt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (q_in_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	// serialize each job into result beats
	utt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.utf8_byte  (utf8_byte),
		.kind       (kind),
		.run_end    (run_end),
		.string_end (string_end)
	);

endmodule

// File: dv/utf16_to_utf8_transcoder_check.sv
// Checker for the UTF-16 to UTF-8 transcoder: watches both channels, predicts the UTF-8 beats
// of every accepted code unit and compares them in order with the output channel.
// Depends on utt_pkg (kind_t).
`timescale 1ns / 100ps

module utf16_to_utf8_transcoder_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [15:0] code_unit,
	input  logic        last_unit,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  utf8_byte,
	input  logic [1:0]  kind,
	input  logic        run_end,
	input  logic        string_end,
	output int          mismatch_count,
	output int          beats_owed
);
	import utt_pkg::*;

	localparam logic [15:0] HighFirst  = 16'hD800;
	localparam logic [15:0] LowFirst   = 16'hDC00;
	localparam logic [15:0] LowEnd     = 16'hE000;
	localparam logic [20:0] SuppOffset = 21'h10000;
	localparam int          ShownMax   = 10;

	typedef struct packed {
		logic [7:0] octet;
		kind_t      kind;
		logic       run_end;
		logic       str_end;
	} utf8_beat_t;

	utf8_beat_t utf8_due_q[$];

	// shadow of the block's string state
	logic       allow_partial;
	logic [9:0] held_high;
	logic       held_valid;
	logic       skipping;

	// beats of the unit under prediction
	utf8_beat_t unit_beats[4];
	int         n_beats;

	task add_beat(input logic [7:0] octet, input kind_t k, input logic se);
		unit_beats[n_beats].octet   = octet;
		unit_beats[n_beats].kind    = k;
		unit_beats[n_beats].run_end = 1'b0;
		unit_beats[n_beats].str_end = se;
		n_beats++;
	endtask

	task encode_cp(input logic [20:0] cp, input logic se);
		if (cp < 21'h80) begin
			add_beat({1'b0, cp[6:0]}, KIND_DATA, se);
		end else if (cp < 21'h800) begin
			add_beat({3'b110, cp[10:6]}, KIND_DATA, 1'b0);
			add_beat({2'b10, cp[5:0]}, KIND_DATA, se);
		end else if (cp < 21'h10000) begin
			add_beat({4'b1110, cp[15:12]}, KIND_DATA, 1'b0);
			add_beat({2'b10, cp[11:6]}, KIND_DATA, 1'b0);
			add_beat({2'b10, cp[5:0]}, KIND_DATA, se);
		end else begin
			add_beat({5'b11110, cp[20:18]}, KIND_DATA, 1'b0);
			add_beat({2'b10, cp[17:12]}, KIND_DATA, 1'b0);
			add_beat({2'b10, cp[11:6]}, KIND_DATA, 1'b0);
			add_beat({2'b10, cp[5:0]}, KIND_DATA, se);
		end
	endtask

	task clear_string();
		held_high  = '0;
		held_valid = 1'b0;
		skipping   = 1'b0;
	endtask

	task predict_utf8(input logic [15:0] cu, input logic lst);
		logic        ends;
		logic [20:0] cp;
		int          i;
		ends    = lst || (cu == 16'h0000);
		n_beats = 0;
		if (skipping) begin
			if (ends)
				clear_string();
		end else if (cu == 16'h0000) begin
			if (held_valid && !allow_partial)
				add_beat(8'h00, KIND_PARTIAL, 1'b1);
			clear_string();
		end else if (cu >= LowFirst && cu < LowEnd) begin
			if (held_valid) begin
				cp = SuppOffset + {held_high, cu[9:0]};
				held_valid = 1'b0;
				held_high  = '0;
				encode_cp(cp, lst);
				if (lst)
					clear_string();
			end else begin
				add_beat(8'h00, KIND_INVALID, lst);
				if (lst)
					clear_string();
				else
					skipping = 1'b1;
			end
		end else if (held_valid) begin
			// high surrogate followed by something other than a low one
			add_beat(8'h00, KIND_INVALID, lst);
			held_valid = 1'b0;
			held_high  = '0;
			if (lst)
				clear_string();
			else
				skipping = 1'b1;
		end else if (cu >= HighFirst && cu < LowFirst) begin
			if (lst) begin
				if (!allow_partial)
					add_beat(8'h00, KIND_PARTIAL, 1'b1);
				clear_string();
			end else begin
				held_high  = cu[9:0];
				held_valid = 1'b1;
			end
		end else begin
			encode_cp({5'd0, cu}, lst);
			if (lst)
				clear_string();
		end
		for (i = 0; i < n_beats; i++) begin
			if (i == n_beats - 1)
				unit_beats[i].run_end = 1'b1;
			utf8_due_q.push_back(unit_beats[i]);
		end
	endtask

	task check_beat();
		utf8_beat_t want;
		if (utf8_due_q.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= ShownMax)
				$display("%0t: unexpected beat byte %h kind %0d run_end %b string_end %b",
					$realtime, utf8_byte, kind, run_end, string_end);
		end else begin
			want = utf8_due_q.pop_front();
			if (want.octet !== utf8_byte || want.kind !== kind
					|| want.run_end !== run_end || want.str_end !== string_end) begin
				mismatch_count++;
				if (mismatch_count <= ShownMax) begin
					$write("%0t: beat mismatch: expected byte %h kind %0d run_end %b",
						$realtime, want.octet, want.kind, want.run_end);
					$display(" string_end %b, got byte %h kind %0d run_end %b string_end %b",
						want.str_end, utf8_byte, kind, run_end, string_end);
				end
			end
		end
	endtask

	// Output is checked before the same-edge input is predicted: the block
	// cannot answer a unit on the edge that takes it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf8_due_q.delete();
			allow_partial  = 1'b0;
			clear_string();
			mismatch_count = 0;
			beats_owed    <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_beat();
			if (cfg_wr_en)
				allow_partial = cfg_wr_data;
			if (in_valid && !in_stall)
				predict_utf8(code_unit, last_unit);
			beats_owed <= utf8_due_q.size();
		end
	end

endmodule

// File: dv/utf16_to_utf8_transcoder_test.sv
// Testbench top for the UTF-16 to UTF-8 transcoder: clock, reset, code unit stimulus,
// output stall pattern, watchdog and verdict.
// Depends on utf16_to_utf8_transcoder and utf16_to_utf8_transcoder_check.
`timescale 1ns / 100ps

module utf16_to_utf8_transcoder_test;

	localparam int IdleLimit    = 2000;  // cycles with no beat on either side
	localparam int RandomUnits  = 180;
	localparam int RandomPhases = 4;
	localparam int SettleCycles = 8;     // lets the block settle after the drain, with margin

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] code_unit;
	logic        last_unit;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  utf8_byte;
	logic [1:0]  kind;
	logic        run_end;
	logic        string_end;

	int mismatch_count;
	int beats_owed;
	int units_sent;
	bit steady;  // 1: no gaps on either side

	utf16_to_utf8_transcoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.code_unit  (code_unit),
		.last_unit  (last_unit),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.utf8_byte  (utf8_byte),
		.kind       (kind),
		.run_end    (run_end),
		.string_end (string_end)
	);

	utf16_to_utf8_transcoder_check u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.code_unit     (code_unit),
		.last_unit     (last_unit),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.utf8_byte     (utf8_byte),
		.kind          (kind),
		.run_end       (run_end),
		.string_end    (string_end),
		.mismatch_count(mismatch_count),
		.beats_owed    (beats_owed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Gap before a unit: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Non-surrogate, nonzero unit spread over the 1-, 2- and 3-byte ranges.
	function automatic logic [15:0] pick_bmp();
		logic [15:0] u;
		case ($urandom_range(0, 3))
			0:       u = 16'($urandom_range(16'h0001, 16'h007F));
			1:       u = 16'($urandom_range(16'h0080, 16'h07FF));
			2:       u = 16'($urandom_range(16'h0800, 16'hD7FF));
			default: u = 16'($urandom_range(16'hE000, 16'hFFFF));
		endcase
		return u;
	endfunction

	// One input beat. valid stays high into the next unit when that one has
	// no gap, so valid is never dropped and raised in the same step.
	task automatic send_unit(input logic [15:0] cu, input logic lst);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		code_unit <= cu;
		last_unit <= lst;
		in_valid  <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		units_sent++;
	endtask

	// Hold the sender until every predicted beat is out, then let the block
	// settle in case the last unit produced nothing (zero unit, held high).
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (beats_owed != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Only called with the block idle.
	task automatic write_cfg(input logic allow);
		cfg_wr_data <= allow;
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// A string of mostly well-formed content with some broken pieces mixed in,
	// closed either by the last flag or by a zero unit.
	task automatic send_random_string();
		logic [15:0] units [0:15];
		int          count;
		int          len;
		int          i;
		bit          by_zero;
		count = 0;
		len   = $urandom_range(1, 6);
		for (i = 0; i < len; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					units[count] = pick_bmp();
					count++;
				end
				4, 5, 6: begin
					// well-formed surrogate pair
					units[count]     = 16'hD800 | 16'($urandom_range(0, 1023));
					units[count + 1] = 16'hDC00 | 16'($urandom_range(0, 1023));
					count += 2;
				end
				7: begin
					units[count] = 16'hDC00 | 16'($urandom_range(0, 1023));
					count++;
				end
				8: begin
					units[count] = 16'hD800 | 16'($urandom_range(0, 1023));
					count++;
				end
				default: begin
					units[count] = 16'($urandom_range(0, 16'hFFFF));
					count++;
				end
			endcase
		end
		by_zero = ($urandom_range(0, 3) == 0);
		for (i = 0; i < count; i++)
			send_unit(units[i], !by_zero && (i == count - 1));
		if (by_zero)
			send_unit(16'h0000, 1'($urandom_range(0, 1)));
	endtask

	// Output stall pattern: short open windows, stalls mostly short, a few long.
	initial begin
		int run;
		int r;
		out_stall = 1'b0;
		forever begin
			if (steady) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				out_stall <= 1'b0;
				run = $urandom_range(1, 8);
				repeat (run) @(posedge clk);
				if (!steady) begin
					r = $urandom_range(0, 99);
					if (r < 60)
						run = $urandom_range(1, 3);
					else if (r < 92)
						run = $urandom_range(4, 10);
					else
						run = $urandom_range(20, 40);
					out_stall <= 1'b1;
					repeat (run) @(posedge clk);
				end
			end
		end
	end

	// Watchdog: too long without a beat on either channel ends the run.
	initial begin
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < IdleLimit) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("utf16_to_utf8_transcoder_test: errors");
		$finish;
	end

	initial begin
		int base;
		int p;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 1'b0;
		in_valid    = 1'b0;
		code_unit   = '0;
		last_unit   = 1'b0;
		steady      = 1'b0;
		units_sent  = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed, trailing partial reported.
		write_cfg(1'b0);
		// encoding length boundaries, string closed by the last flag
		send_unit(16'h0041, 1'b0);
		send_unit(16'h007F, 1'b0);
		send_unit(16'h0080, 1'b0);
		send_unit(16'h07FF, 1'b0);
		send_unit(16'h0800, 1'b0);
		send_unit(16'hFFFF, 1'b0);
		send_unit(16'hE000, 1'b1);
		// lowest and highest supplementary code points
		send_unit(16'hD800, 1'b0);
		send_unit(16'hDC00, 1'b0);
		send_unit(16'hDBFF, 1'b0);
		send_unit(16'hDFFF, 1'b1);
		// lone low surrogate, rest of string dropped up to the zero unit
		send_unit(16'hDC00, 1'b0);
		send_unit(16'h0041, 1'b0);
		send_unit(16'h0000, 1'b0);
		// lone low surrogate that is also last
		send_unit(16'hDFFF, 1'b1);
		// high surrogate then a BMP unit; the last-flagged high is dropped
		send_unit(16'hD800, 1'b0);
		send_unit(16'h0042, 1'b0);
		send_unit(16'hD801, 1'b1);
		// high surrogate then another high flagged last
		send_unit(16'hDA00, 1'b0);
		send_unit(16'hDB00, 1'b1);
		// high surrogate pending at a zero unit, and a last-flagged high
		send_unit(16'hD900, 1'b0);
		send_unit(16'h0000, 1'b0);
		send_unit(16'hDBFF, 1'b1);
		// bare terminator
		send_unit(16'h0000, 1'b0);
		drain_results();

		// Directed, trailing partial dropped silently.
		write_cfg(1'b1);
		send_unit(16'hD800, 1'b0);
		send_unit(16'h0000, 1'b1);
		send_unit(16'hDBFF, 1'b1);
		send_unit(16'h00E9, 1'b1);
		drain_results();

		// Random phases alternate the setting; phase 2 runs without gaps.
		base = units_sent;
		for (p = 0; p < RandomPhases; p++) begin
			write_cfg(p[0]);
			steady = (p == 2);
			while (units_sent - base < (p + 1) * RandomUnits / RandomPhases)
				send_random_string();
			drain_results();
		end
		steady = 1'b0;

		if (mismatch_count == 0)
			$display("utf16_to_utf8_transcoder_test: clean");
		else
			$display("utf16_to_utf8_transcoder_test: errors");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/utt_pkg.sv
sv/utt_queue.sv
sv/utt_front.sv
sv/utt_back.sv
sv/utf16_to_utf8_transcoder.sv
dv/utf16_to_utf8_transcoder_check.sv
dv/utf16_to_utf8_transcoder_test.sv
